// ----- src/mfde_pkg.sv -----
// ----------------------------------------------------------------------------
// mfde_pkg: shared types and constants of the frame store draw engine
// Frame geometry, request codes and the command record passed to the back end.
// ----------------------------------------------------------------------------
package mfde_pkg;
	localparam int ROWS      = 64;
	localparam int COLS      = 128;
	localparam int STRIDE    = (COLS + 7) / 8;
	localparam int FB_BYTES  = ROWS * STRIDE;
	localparam int AW        = $clog2(FB_BYTES);

	localparam logic [2:0] REQ_FILL  = 3'd0;
	localparam logic [2:0] REQ_PIXEL = 3'd1;
	localparam logic [2:0] REQ_COL   = 3'd2;
	localparam logic [2:0] REQ_ROW   = 3'd3;
	localparam logic [2:0] REQ_IMG   = 3'd4;
	localparam logic [2:0] REQ_CLR   = 3'd5;
	localparam logic [2:0] REQ_READ  = 3'd6;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  y_pos;
		logic [7:0]  x_pos;
		logic [7:0]  y_end_or_size;
		logic [7:0]  x_end_or_width;
		logic        pixel_value;
		logic [31:0] data;
		logic        last;
		logic [7:0]  margin;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [6:0] dirty_top;
		logic [7:0] dirty_left;
		logic [6:0] dirty_bottom;
		logic [7:0] dirty_right;
	} res_t;
endpackage

// ----- src/mfde_if.sv -----
// ----------------------------------------------------------------------------
// mfde_req_if / mfde_res_if / mfde_cfg_if: valid-ready channels
// Request, result and configuration write channels.
// ----------------------------------------------------------------------------
interface mfde_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [7:0]  y_pos;
	logic [7:0]  x_pos;
	logic [7:0]  y_end_or_size;
	logic [7:0]  x_end_or_width;
	logic        pixel_value;
	logic [31:0] data;
	logic        last;
	modport source (output valid, req_type, y_pos, x_pos, y_end_or_size, x_end_or_width,
		pixel_value, data, last, input ready);
	modport sink (input valid, req_type, y_pos, x_pos, y_end_or_size, x_end_or_width,
		pixel_value, data, last, output ready);
endinterface

interface mfde_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [6:0] dirty_top;
	logic [7:0] dirty_left;
	logic [6:0] dirty_bottom;
	logic [7:0] dirty_right;
	modport source (output valid, read_data, dirty_top, dirty_left, dirty_bottom,
		dirty_right, input ready);
	modport sink (input valid, read_data, dirty_top, dirty_left, dirty_bottom,
		dirty_right, output ready);
endinterface

interface mfde_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- src/mfde_ram.sv -----
// ----------------------------------------------------------------------------
// mfde_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- src/mfde_front.sv -----
// ----------------------------------------------------------------------------
// mfde_front: request intake and command queue
// Capture requests with the margin setting and queue them for the back end.
// ----------------------------------------------------------------------------
module mfde_front import mfde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mfde_req_if.sink req,
	input  logic [7:0] margin,
	output logic  cmd_valid,
	input  logic  cmd_take,
	output cmd_t  cmd
);
	cmd_t       q_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	cmd_t       in_c;

	assign req.ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_comb begin
		in_c.req_type       = req.req_type;
		in_c.y_pos          = req.y_pos;
		in_c.x_pos          = req.x_pos;
		in_c.y_end_or_size  = req.y_end_or_size;
		in_c.x_end_or_width = req.x_end_or_width;
		in_c.pixel_value    = req.pixel_value;
		in_c.data           = req.data;
		in_c.last           = req.last;
		in_c.margin         = margin;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			q_q[wp_q] <= in_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				wp_q <= ~wp_q;
			end
			if (cmd_take) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(req.valid && req.ready) - 2'(cmd_take);
		end
	end
endmodule

// ----- src/mfde_back.sv -----
// ----------------------------------------------------------------------------
// mfde_back: command executor
// Sequence frame store byte accesses for each command and keep dirty bounds.
// ----------------------------------------------------------------------------
module mfde_back import mfde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_take,
	input  cmd_t cmd,
	mfde_res_if.source res
);
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_WAIT  = 4'd3;
	localparam logic [3:0] S_MOD   = 4'd4;
	localparam logic [3:0] S_NEXT  = 4'd5;
	localparam logic [3:0] S_OUT   = 4'd6;

	logic [3:0]    st_q;
	cmd_t          c_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    row_q;    // current frame row
	logic [4:0]    col_q;    // current frame byte column
	logic [5:0]    idx_q;    // column bit index
	logic [4:0]    j_q;      // row stream byte within span
	logic [7:0]    dd_q;
	logic [7:0]    rd_q;
	logic [6:0]    dt_q, db_q;
	logic [7:0]    dl_q, dr_q;
	logic [7:0]    s_row_q;
	logic [4:0]    s_byte_q;
	logic [7:0]    carry_q;

	logic           we;
	logic [AW-1:0]  addr;
	logic [7:0]     wdata, rdata;

	mfde_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

	// row stream geometry
	logic [8:0] rs_w, rs_end;
	logic [4:0] rs_first, rs_nb1;
	logic [2:0] rs_s, rs_ls;
	logic       rs_ok;
	always_comb begin
		rs_w = {1'b0, c_q.x_end_or_width};
		if ({1'b0, c_q.x_pos} + rs_w > 9'(COLS)) begin
			rs_w = 9'(COLS) - {1'b0, c_q.x_pos};
		end
		rs_end   = {1'b0, c_q.x_pos} + rs_w - 9'd1;
		rs_first = c_q.x_pos[7:3];
		rs_nb1   = rs_end[7:3] - rs_first;
		rs_s     = c_q.x_pos[2:0];
		rs_ls    = 3'd7 - rs_end[2:0];
		rs_ok    = (c_q.y_pos < 8'(ROWS)) && (c_q.x_pos < 8'(COLS)) && (rs_w != 9'd0);
	end

	// fill mask for current byte
	logic [7:0] fmask;
	logic [7:0] f_right;
	always_comb begin
		f_right = (c_q.x_end_or_width > 8'(COLS)) ? 8'(COLS) : c_q.x_end_or_width;
		for (int b = 0; b < 8; b++) begin
			fmask[7-b] = ({col_q, 3'(b)} >= c_q.x_pos) && ({col_q, 3'(b)} < f_right);
		end
	end

	logic [7:0] bit_mask;
	assign bit_mask = 8'h80 >> c_q.x_pos[2:0];

	logic       col_bit;
	assign col_bit = ((idx_q < 6'd32) ? c_q.data[idx_q[4:0]] : 1'b0) ^ c_q.pixel_value;

	// image stream width in whole bytes
	logic [4:0] wb;
	assign wb = c_q.x_end_or_width[7:3];

	// new byte computed in S_MOD
	logic [7:0] nv;
	logic       do_wr, mark;
	logic [7:0] rs_val, rs_lm;
	always_comb begin
		rs_val = carry_q | (dd_q >> rs_s);
		rs_lm  = 8'((9'd1 << rs_ls) - 9'd1);
		nv = rdata;
		do_wr = 1'b0;
		mark = 1'b0;
		case (c_q.req_type)
			REQ_FILL: begin
				nv = c_q.pixel_value ? (rdata | fmask) : (rdata & ~fmask);
				do_wr = 1'b1;
			end
			REQ_PIXEL: begin
				nv = c_q.pixel_value ? (rdata | bit_mask) : (rdata & ~bit_mask);
				do_wr = 1'b1;
				mark = (nv != rdata);
			end
			REQ_COL: begin
				nv = col_bit ? (rdata | bit_mask) : (rdata & ~bit_mask);
				do_wr = 1'b1;
				mark = (nv != rdata);
			end
			REQ_ROW: begin
				if (j_q == rs_nb1) begin
					nv = (rs_val & ~rs_lm) | (rdata & rs_lm);
				end else begin
					nv = rs_val;
				end
				// the carry loading pass only reads
				do_wr = !(j_q == 5'd0 && s_byte_q == 5'd0 && idx_q == 6'd0);
				mark = (nv != rdata);
			end
			REQ_IMG: begin
				nv = c_q.data[7:0];
				do_wr = 1'b1;
			end
			default: ;
		endcase
	end

	logic [6:0] mk_t, mk_b;
	logic [7:0] mk_l, mk_r;
	always_comb begin
		mk_t = row_q[6:0];
		mk_b = row_q[6:0] + 7'd1;
		if (c_q.req_type == REQ_ROW) begin
			mk_l = {col_q, 3'd0};
		end else begin
			mk_l = c_q.x_pos;
		end
		mk_r = mk_l + 8'd1;
	end

	// image final rectangle
	logic [8:0] ib, ir;
	assign ib = ({1'b0, c_q.y_pos} + {1'b0, c_q.y_end_or_size} > 9'(ROWS)) ? 9'(ROWS)
		: {1'b0, c_q.y_pos} + {1'b0, c_q.y_end_or_size};
	assign ir = ({1'b0, c_q.x_pos} + {1'b0, c_q.x_end_or_width} > 9'(COLS)) ? 9'(COLS)
		: {1'b0, c_q.x_pos} + {1'b0, c_q.x_end_or_width};

	always_comb begin
		we = 1'b0;
		addr = clr_q;
		wdata = '0;
		case (st_q)
			S_CLEAR: we = 1'b1;
			S_MOD: begin
				addr = AW'({row_q[5:0], col_q[3:0]});
				we = do_wr;
				wdata = nv;
			end
			default: addr = AW'({row_q[5:0], col_q[3:0]});
		endcase
	end

	assign cmd_take = (st_q == S_IDLE) && cmd_valid;
	assign res.valid = (st_q == S_OUT);
	assign res.read_data = rd_q;
	assign res.dirty_top = dt_q;
	assign res.dirty_left = dl_q;
	assign res.dirty_bottom = db_q;
	assign res.dirty_right = dr_q;

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			c_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			clr_q <= '0;
			row_q <= '0; col_q <= '0; idx_q <= '0; j_q <= '0; dd_q <= '0; rd_q <= '0;
			dt_q <= 7'(ROWS); dl_q <= 8'(COLS); db_q <= '0; dr_q <= '0;
			s_row_q <= '0; s_byte_q <= '0; carry_q <= '0;
		end else begin
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(FB_BYTES - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						st_q <= S_RD;
						rd_q <= '0;
					end
				end
				S_RD: begin
					st_q <= S_OUT;
					row_q <= c_q.y_pos;
					col_q <= c_q.x_pos[7:3];
					idx_q <= '0;
					j_q <= s_byte_q;
					dd_q <= c_q.data[7:0] ^ {8{c_q.pixel_value}};
					case (c_q.req_type)
						REQ_FILL: begin
							if (c_q.x_pos < f_right && c_q.y_pos < c_q.y_end_or_size
								&& c_q.y_pos < 8'(ROWS)) begin
								st_q <= S_WAIT;
							end
						end
						REQ_PIXEL: begin
							if (c_q.y_pos < 8'(ROWS) && c_q.x_pos < 8'(COLS)
								&& c_q.x_pos < c_q.margin) begin
								st_q <= S_WAIT;
							end
						end
						REQ_COL: begin
							if (c_q.x_pos < 8'(COLS) && c_q.y_end_or_size != 8'd0
								&& c_q.y_pos < 8'(ROWS)) begin
								st_q <= S_WAIT;
							end
						end
						REQ_ROW: begin
							if (rs_ok) begin
								if (s_byte_q == 5'd0) begin
									col_q <= rs_first;
									st_q <= S_WAIT;
								end else if (s_byte_q <= rs_nb1) begin
									col_q <= rs_first + s_byte_q;
									st_q <= S_WAIT;
								end else begin
									st_q <= S_NEXT;
								end
							end else begin
								st_q <= S_NEXT;
							end
						end
						REQ_IMG: begin
							if (s_byte_q < wb && s_row_q < c_q.y_end_or_size
								&& {1'b0, s_row_q} + {1'b0, c_q.y_pos} < 9'(ROWS)
								&& {1'b0, c_q.x_pos[7:3]} + {1'b0, s_byte_q} < 6'(STRIDE)) begin
								row_q <= s_row_q + c_q.y_pos;
								col_q <= c_q.x_pos[7:3] + s_byte_q;
								st_q <= S_MOD;
							end else begin
								st_q <= S_NEXT;
							end
						end
						REQ_CLR: begin
							dt_q <= 7'(ROWS); dl_q <= 8'(COLS); db_q <= '0; dr_q <= '0;
						end
						REQ_READ: begin
							if (c_q.y_pos < 8'(ROWS) && c_q.x_pos < 8'(COLS)) begin
								st_q <= S_WAIT;
							end
						end
						default: ;
					endcase
				end
				S_WAIT: begin
					// read data of the addressed byte arrives next cycle
					st_q <= S_MOD;
				end
				S_MOD: begin
					if (c_q.req_type == REQ_READ) begin
						rd_q <= rdata;
						st_q <= S_OUT;
					end else if (c_q.req_type == REQ_IMG) begin
						st_q <= S_NEXT;
					end else if (c_q.req_type == REQ_ROW && j_q == 5'd0
						&& s_byte_q == 5'd0 && idx_q == 6'd0) begin
						// first pass loads carry from the left partial byte
						carry_q <= rdata & 8'(9'h1FF << (4'd8 - {1'b0, rs_s}));
						idx_q <= 6'd1;
						st_q <= S_WAIT;
					end else begin
						if (mark) begin
							if (mk_t < dt_q) dt_q <= mk_t;
							if (mk_b > db_q) db_q <= mk_b;
							if (mk_l < dl_q) dl_q <= mk_l;
							if (mk_r > dr_q) dr_q <= mk_r;
						end
						st_q <= S_OUT;
						case (c_q.req_type)
							REQ_FILL: begin
								if ({col_q, 3'd7} + 8'd1 < f_right && col_q != 5'(STRIDE - 1)) begin
									col_q <= col_q + 5'd1;
									st_q <= S_WAIT;
								end else if (row_q + 8'd1 < c_q.y_end_or_size
									&& row_q + 8'd1 < 8'(ROWS)) begin
									row_q <= row_q + 8'd1;
									col_q <= c_q.x_pos[7:3];
									st_q <= S_WAIT;
								end else begin
									st_q <= S_NEXT;
								end
							end
							REQ_COL: begin
								if (idx_q + 6'd1 < {1'b0, c_q.y_end_or_size[4:0]}
									|| (c_q.y_end_or_size > 8'd31 && idx_q != 6'd63)) begin
									if (row_q + 8'd1 < 8'(ROWS)
										&& {2'b0, idx_q} + 8'd1 < c_q.y_end_or_size) begin
										row_q <= row_q + 8'd1;
										idx_q <= idx_q + 6'd1;
										st_q <= S_WAIT;
									end
								end
							end
							REQ_ROW: begin
								st_q <= S_NEXT;
								if (j_q != rs_nb1) begin
									carry_q <= 8'({dd_q, 8'd0} >> rs_s);
									if (c_q.last) begin
										j_q <= j_q + 5'd1;
										col_q <= col_q + 5'd1;
										dd_q <= {8{c_q.pixel_value}};
										st_q <= S_WAIT;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_NEXT: begin
					st_q <= S_OUT;
					if (c_q.req_type == REQ_ROW) begin
						if (c_q.last) begin
							s_byte_q <= '0; carry_q <= '0;
						end else if (s_byte_q != 5'd31) begin
							s_byte_q <= s_byte_q + 5'd1;
						end
					end
					if (c_q.req_type == REQ_IMG) begin
						if (wb != 5'd0) begin
							if ({1'b0, s_byte_q} + 6'd1 >= {1'b0, wb}) begin
								s_byte_q <= '0;
								if (s_row_q != 8'd255) s_row_q <= s_row_q + 8'd1;
							end else begin
								s_byte_q <= s_byte_q + 5'd1;
							end
						end
						if (c_q.last) begin
							s_row_q <= '0; s_byte_q <= '0; carry_q <= '0;
							if (c_q.y_pos < 8'(ROWS) && c_q.x_pos < 8'(COLS)
								&& c_q.y_end_or_size != 8'd0 && c_q.x_end_or_width != 8'd0) begin
								if (c_q.y_pos[6:0] < dt_q) dt_q <= c_q.y_pos[6:0];
								if (ib[6:0] > db_q) db_q <= ib[6:0];
								if (c_q.x_pos < dl_q) dl_q <= c_q.x_pos;
								if (ir[7:0] > dr_q) dr_q <= ir[7:0];
							end
						end
					end
					if (c_q.req_type == REQ_FILL) begin
						if (c_q.y_pos[6:0] < dt_q) dt_q <= c_q.y_pos[6:0];
						if (row_q[6:0] + 7'd1 > db_q) db_q <= row_q[6:0] + 7'd1;
						if (c_q.x_pos < dl_q) dl_q <= c_q.x_pos;
						if (f_right > dr_q) dr_q <= f_right;
					end
				end
				S_OUT: begin
					if (res.ready) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/mono_framebuffer_draw_engine.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine: 1 bpp frame store drawing engine
// Draw commands into a 64x128 frame store and report the dirty rectangle.
// ----------------------------------------------------------------------------
// channel | dir | carries
// req     | in  | one draw request
// res     | out | read byte and dirty bounds, one per request
// cfg     | in  | right margin for single pixel writes
//
// Steps: a request is taken, decoded and answered with a result; each frame
// store byte it reads and rewrites passes a wait state and a modify state; fills,
// row and image bytes add a closing state, an image byte writes with no read, and
// a row stream's first byte reads twice. A full-screen fill walks 64 rows of 16 bytes.
// Reset: a clearing pass zeroes every frame store byte; requests wait.
// Stalls: a two-entry queue lets requests enter while the executor works
// or holds a result.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine import mfde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mfde_req_if.sink   req,
	mfde_res_if.source res,
	mfde_cfg_if.sink   cfg
);
	logic [7:0] margin_q;
	logic       cmd_valid, cmd_take;
	cmd_t       cmd;

	// hold the margin; it is to be written only while idle, which the user must ensure
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 8'd128;
		end else if (cfg.valid) begin
			margin_q <= cfg.data;
		end
	end

	mfde_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .margin(margin_q),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd));

	mfde_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .res(res));

	// dirty bounds never pass the display size
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.dirty_bottom <= 7'(ROWS) && res.dirty_right <= 8'(COLS)))
		else $error("dirty bounds out of range");
	// a result holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.read_data))
		else $error("result dropped while stalled");
	// take a queued command only when one is there
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken from empty queue");
endmodule

// ----- tb/mono_framebuffer_draw_engine_tb.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_tb: self-checking bench for the draw engine
// Drives directed and random draw requests, margin writes and stream
// sequences, and checks each result against an in-bench frame store model.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mfde_pkg::*;

	typedef struct {
		logic [2:0]  req_type;
		logic [7:0]  y_pos;
		logic [7:0]  x_pos;
		logic [7:0]  y_end_or_size;
		logic [7:0]  x_end_or_width;
		logic        pixel_value;
		logic [31:0] data;
		logic        last;
	} draw_req_t;

	localparam logic [2:0] REQ_NOP = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mfde_req_if req_ch();
	mfde_res_if res_ch();
	mfde_cfg_if cfg_ch();

	mono_framebuffer_draw_engine dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .res(res_ch), .cfg(cfg_ch)
	);

	always #4 clk = ~clk;

	// Model of the frame store, the dirty bounds and the stream state.
	logic [7:0]  pic [FB_BYTES];
	int unsigned dtop, dleft, dbot, dright;
	int unsigned strm_row, strm_byte, carry;
	int unsigned margin_reg;

	res_t expected_res [$];
	int   err_count = 0;
	bit   calm = 1'b0;  // when set, neither side idles

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic void mark_rect(int unsigned t, int unsigned l, int unsigned b,
		int unsigned r);
		if (t > ROWS) t = ROWS;
		if (b > ROWS) b = ROWS;
		if (l > COLS) l = COLS;
		if (r > COLS) r = COLS;
		if (t < dtop) dtop = t;
		if (b > dbot) dbot = b;
		if (l < dleft) dleft = l;
		if (r > dright) dright = r;
	endfunction

	// Return 1 if the pixel changed.
	function automatic bit put_px(int unsigned r, int unsigned c, bit v);
		int unsigned idx;
		logic [7:0]  mask, nv;
		idx = r * STRIDE + (c >> 3);
		mask = 8'h80 >> (c & 7);
		nv = v ? (pic[idx] | mask) : (pic[idx] & ~mask);
		if (nv != pic[idx]) begin
			pic[idx] = nv;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void put_row_byte(int unsigned top, int unsigned col, int unsigned val);
		int unsigned idx;
		idx = top * STRIDE + col;
		if (pic[idx] != val[7:0]) begin
			pic[idx] = val[7:0];
			mark_rect(top, 8 * col, top + 1, 8 * col + 1);
		end
	endfunction

	function automatic void row_bitmap(int unsigned top, int unsigned left, int unsigned w,
		int unsigned inv, int unsigned d, bit last);
		int unsigned first, nb, s, ls, j, dd, lm, acc;
		if (top < ROWS && left < COLS) begin
			if (left + w > COLS) w = COLS - left;
			if (w != 0) begin
				first = left >> 3;
				nb = ((left + w - 1) >> 3) - first + 1;
				s = left & 7;
				ls = 7 - ((left + w - 1) & 7);
				j = strm_byte;
				dd = (d ^ inv) & 8'hFF;
				if (j == 0)
					carry = pic[top * STRIDE + first] & ((32'hFF << (8 - s)) & 8'hFF);
				forever begin
					if (j >= nb) break;
					if (j == nb - 1) begin
						lm = (1 << ls) - 1;
						acc = ((carry | (dd >> s)) & ~lm & 8'hFF)
							| (pic[top * STRIDE + first + j] & lm);
						put_row_byte(top, first + j, acc);
						break;
					end
					put_row_byte(top, first + j, carry | (dd >> s));
					carry = (dd << (8 - s)) & 8'hFF;
					if (!last) break;
					j++;
					dd = inv;
				end
			end
		end
		if (last) begin
			strm_byte = 0;
			carry = 0;
		end else if (strm_byte < 31) begin
			strm_byte++;
		end
	endfunction

	function automatic void image_bitmap(int unsigned y0, int unsigned x0, int unsigned h,
		int unsigned w, int unsigned d, bit last);
		int unsigned wb, r, c;
		wb = w >> 3;
		r = strm_row;
		c = strm_byte;
		if (c < wb && r < h && r + y0 < ROWS && (x0 >> 3) + c < STRIDE)
			pic[(r + y0) * STRIDE + (x0 >> 3) + c] = d[7:0];
		if (wb != 0) begin
			c++;
			if (c >= wb) begin
				c = 0;
				if (r < 255) r++;
			end
			strm_row = r;
			strm_byte = c & 31;
		end
		if (last) begin
			if (y0 < ROWS && x0 < COLS && h != 0 && w != 0)
				mark_rect(y0, x0, y0 + h, x0 + w);
			strm_row = 0;
			strm_byte = 0;
			carry = 0;
		end
	endfunction

	// Advance the model by one request and return the result it yields.
	function automatic res_t predict_draw(input draw_req_t q);
		int unsigned y, x, ye, xe, right, bottom, i, rr;
		logic [7:0] rd;
		res_t o;
		y = q.y_pos; x = q.x_pos; ye = q.y_end_or_size; xe = q.x_end_or_width;
		rd = 8'h00;
		case (q.req_type)
			REQ_FILL: begin
				right = (xe > COLS) ? COLS : xe;
				bottom = (ye > ROWS) ? ROWS : ye;
				if (x < right && y < bottom) begin
					for (int unsigned r = y; r < bottom; r++)
						for (int unsigned c = x; c < right; c++)
							void'(put_px(r, c, q.pixel_value));
					mark_rect(y, x, bottom, right);
				end
			end
			REQ_PIXEL: begin
				if (y < ROWS && x < COLS && x < margin_reg && put_px(y, x, q.pixel_value))
					mark_rect(y, x, y + 1, x + 1);
			end
			REQ_COL: begin
				if (x < COLS) begin
					for (i = 0; i < ye; i++) begin
						rr = y + i;
						if (rr >= ROWS) break;
						if (put_px(rr, x, ((i < 32) ? q.data[i] : 1'b0) ^ q.pixel_value))
							mark_rect(rr, x, rr + 1, x + 1);
					end
				end
			end
			REQ_ROW: row_bitmap(y, x, xe, q.pixel_value ? 8'hFF : 0, q.data[7:0], q.last);
			REQ_IMG: image_bitmap(y, x, ye, xe, q.data[7:0], q.last);
			REQ_CLR: begin
				dtop = ROWS; dleft = COLS; dbot = 0; dright = 0;
			end
			REQ_READ: if (y < ROWS && x < COLS) rd = pic[y * STRIDE + (x >> 3)];
			default: ;
		endcase
		o.read_data = rd;
		o.dirty_top = dtop[6:0];
		o.dirty_left = dleft[7:0];
		o.dirty_bottom = dbot[6:0];
		o.dirty_right = dright[7:0];
		return o;
	endfunction

	// Send one request: maybe idle first, then hold it until accepted.
	task automatic send_draw(input draw_req_t q);
		expected_res.push_back(predict_draw(q));
		@(negedge clk);
		if (!calm && $urandom_range(99) < 30) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		req_ch.req_type <= q.req_type;
		req_ch.y_pos <= q.y_pos;
		req_ch.x_pos <= q.x_pos;
		req_ch.y_end_or_size <= q.y_end_or_size;
		req_ch.x_end_or_width <= q.x_end_or_width;
		req_ch.pixel_value <= q.pixel_value;
		req_ch.data <= q.data;
		req_ch.last <= q.last;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	function automatic draw_req_t mk(logic [2:0] t, int y, int x, int ye, int xe, int pv,
		logic [31:0] d, int last);
		draw_req_t q;
		q.req_type = t; q.y_pos = 8'(y); q.x_pos = 8'(x); q.y_end_or_size = 8'(ye);
		q.x_end_or_width = 8'(xe); q.pixel_value = 1'(pv); q.data = d; q.last = 1'(last);
		return q;
	endfunction

	// Drop valid and wait until every result is back and the engine has settled.
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (expected_res.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_margin(input logic [7:0] v);
		drain();
		@(negedge clk);
		cfg_ch.data <= v;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		margin_reg = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_res.pop_front();
				if (res_ch.read_data !== want.read_data)
					report_mismatch("read_data", res_ch.read_data, want.read_data);
				if (res_ch.dirty_top !== want.dirty_top)
					report_mismatch("dirty_top", res_ch.dirty_top, want.dirty_top);
				if (res_ch.dirty_left !== want.dirty_left)
					report_mismatch("dirty_left", res_ch.dirty_left, want.dirty_left);
				if (res_ch.dirty_bottom !== want.dirty_bottom)
					report_mismatch("dirty_bottom", res_ch.dirty_bottom, want.dirty_bottom);
				if (res_ch.dirty_right !== want.dirty_right)
					report_mismatch("dirty_right", res_ch.dirty_right, want.dirty_right);
			end
		end
	end

	// Stall the result side with a 30 percent chance, except in calm stretches.
	always @(negedge clk)
		res_ch.ready <= calm || ($urandom_range(99) >= 30);

	// Directed: extremes, every request code and the clipping corners.
	task automatic test_directed();
		send_draw(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
		send_draw(mk(REQ_FILL, 0, 0, 255, 255, 1, 0, 0));
		send_draw(mk(REQ_READ, 63, 127, 0, 0, 0, 0, 0));
		send_draw(mk(REQ_CLR, 0, 0, 0, 0, 0, 0, 0));
		send_draw(mk(REQ_FILL, 10, 20, 30, 20, 0, 0, 0));     // empty rectangle
		send_draw(mk(REQ_FILL, 5, 3, 9, 21, 0, 0, 0));
		send_draw(mk(REQ_PIXEL, 63, 127, 0, 0, 0, 0, 0));
		send_draw(mk(REQ_PIXEL, 64, 5, 0, 0, 1, 0, 0));       // row off display
		send_draw(mk(REQ_PIXEL, 6, 128, 0, 0, 1, 0, 0));      // column off display
		send_draw(mk(REQ_PIXEL, 6, 4, 0, 0, 1, 0, 0));        // sets a pixel the fill cleared
		send_draw(mk(REQ_COL, 20, 100, 40, 0, 0, 32'hA5A5_F00F, 0));
		send_draw(mk(REQ_COL, 50, 7, 255, 0, 1, 32'hFFFF_FFFF, 0));
		send_draw(mk(REQ_COL, 0, 200, 8, 0, 0, 32'h1, 0));    // column off display
		send_draw(mk(REQ_ROW, 30, 3, 0, 13, 1, 8'h5C, 0));
		send_draw(mk(REQ_ROW, 30, 3, 0, 13, 1, 8'hFF, 1));
		send_draw(mk(REQ_ROW, 31, 122, 0, 255, 0, 8'hE7, 0));
		send_draw(mk(REQ_ROW, 31, 122, 0, 255, 0, 8'h3C, 1));
		send_draw(mk(REQ_ROW, 32, 9, 0, 40, 0, 8'h81, 1));    // early end of row
		send_draw(mk(REQ_IMG, 60, 120, 8, 16, 0, 8'hAA, 0));
		send_draw(mk(REQ_IMG, 60, 120, 8, 16, 0, 8'h55, 1));
		send_draw(mk(REQ_IMG, 2, 2, 3, 4, 0, 8'hFF, 1));      // width below one byte
		send_draw(mk(REQ_READ, 60, 127, 0, 0, 0, 0, 0));
		send_draw(mk(REQ_READ, 255, 255, 0, 0, 0, 0, 0));
		send_draw(mk(REQ_NOP, 255, 255, 255, 255, 1, 32'hFFFF_FFFF, 1));
	endtask

	// Single pixel writes across the margin at the current setting.
	task automatic test_margin_pixels();
		for (int i = 0; i < 20; i++)
			send_draw(mk(REQ_PIXEL, $urandom_range(63), $urandom_range(131), 0, 0,
				$urandom_range(1), $urandom, 0));
		send_draw(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
	endtask

	function automatic int rand_row();
		return ($urandom_range(99) < 10) ? $urandom_range(255) : $urandom_range(ROWS - 1);
	endfunction

	function automatic int rand_col();
		return ($urandom_range(99) < 10) ? $urandom_range(255) : $urandom_range(COLS - 1);
	endfunction

	// Random: mostly well-formed streams and small shapes, some noise.
	task automatic test_random(input int n_items);
		draw_req_t q;
		int sent, kind, y, x, w, h, nb;
		bit pv;
		sent = 0;
		while (sent < n_items) begin
			calm = (sent > n_items / 3 && sent < n_items / 2);
			kind = $urandom_range(99);
			y = rand_row(); x = rand_col(); pv = 1'($urandom_range(1));
			if (kind < 20) begin
				// row bitmap sequence, sometimes ended early or run past its span
				w = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(40, 1);
				nb = ((x & 7) + w + 7) / 8;
				if ($urandom_range(4) == 0) nb = $urandom_range(nb + 2, 1);
				for (int i = 0; i < nb; i++) begin
					send_draw(mk(REQ_ROW, y, x, $urandom, w, pv, $urandom, i == nb - 1));
					sent++;
				end
			end else if (kind < 35) begin
				// image sequence of whole rows, sometimes cut short
				h = $urandom_range(4, 1);
				w = ($urandom_range(4) == 0) ? $urandom_range(255) : 8 * $urandom_range(4, 1);
				nb = (w >> 3) * h;
				if (nb == 0 || nb > 40 || $urandom_range(5) == 0) nb = $urandom_range(6, 1);
				for (int i = 0; i < nb; i++) begin
					send_draw(mk(REQ_IMG, y, x, h, w, pv, $urandom, i == nb - 1));
					sent++;
				end
			end else begin
				if (kind < 47) begin
					if ($urandom_range(49) == 0)
						q = mk(REQ_FILL, $urandom_range(255), $urandom_range(255),
							$urandom_range(255), $urandom_range(255), pv, $urandom, 0);
					else
						q = mk(REQ_FILL, y, x, y + $urandom_range(8), x + $urandom_range(20),
							pv, $urandom, $urandom_range(1));
				end else if (kind < 62)
					q = mk(REQ_PIXEL, y, x, $urandom, $urandom, pv, $urandom, $urandom_range(1));
				else if (kind < 74)
					q = mk(REQ_COL, y, x, ($urandom_range(7) == 0) ? $urandom_range(255)
						: $urandom_range(33), $urandom, pv, $urandom, $urandom_range(1));
				else if (kind < 90)
					q = mk(REQ_READ, y, x, $urandom, $urandom, pv, $urandom, $urandom_range(1));
				else if (kind < 95)
					q = mk(REQ_CLR, y, x, $urandom, $urandom, pv, $urandom, $urandom_range(1));
				else
					q = mk(3'($urandom_range(7)), $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(255), pv, $urandom,
						$urandom_range(1));
				send_draw(q);
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_READ;
		req_ch.y_pos = '0;
		req_ch.x_pos = '0;
		req_ch.y_end_or_size = '0;
		req_ch.x_end_or_width = '0;
		req_ch.pixel_value = 1'b0;
		req_ch.data = '0;
		req_ch.last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		foreach (pic[i]) pic[i] = 8'h00;
		dtop = ROWS; dleft = COLS; dbot = 0; dright = 0;
		strm_row = 0; strm_byte = 0; carry = 0;
		margin_reg = 128;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		write_margin(8'd0);
		test_margin_pixels();
		write_margin(8'd255);
		test_margin_pixels();
		write_margin(8'd64);
		test_margin_pixels();
		test_random(700);
		write_margin(8'd128);
		test_random(700);
		write_margin(8'd13);
		test_random(600);

		drain();
		if (err_count == 0)
			$display("mono_framebuffer_draw_engine_tb: done, clean");
		else
			$display("mono_framebuffer_draw_engine_tb: done, errors");
		$finish;
	end

	// Hold the run to a generous bound; a hang counts as a failure.
	initial begin
		#400_000_000;
		$display("mono_framebuffer_draw_engine_tb: done, errors");
		$finish;
	end
endmodule
